FILE: src/ppbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppbr_pkg
// Shared constants, types and helpers for the page protection bitmap range
// unit.
// ----------------------------------------------------------------------------
package ppbr_pkg;

    // Bitmap geometry
    localparam int BITMAP_BYTES = 131072;
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_SIZE    = 1 << PAGE_SHIFT;

    localparam int ADDR_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int BYTE_IDX_W = $clog2(BITMAP_BYTES);
    localparam int PAGE_W     = BYTE_IDX_W + 3;
    localparam int LAST_W     = PAGE_W + 1;
    // Start plus length plus page size less one carries two bits past the address
    localparam int END_W      = ADDR_W + 2;
    localparam int END_PAGE_W = END_W - PAGE_SHIFT;

    // One past the last page that the bitmap holds
    localparam logic [LAST_W-1:0] PAGE_LIMIT = LAST_W'(BITMAP_BYTES * 8);

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_SET   = 2'd0;
    localparam logic [FUNC_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] OP_TEST  = 2'd2;

    // One read-modify-write of a bitmap byte
    typedef struct packed {
        logic                  valid;
        logic [BYTE_IDX_W-1:0] idx;
        logic [7:0]            mask;
        logic [FUNC_W-1:0]     op;
    } rmw_req_t;

    // Store status back to the sequencer
    typedef struct packed {
        logic init_done;
        logic pending;
        logic hit;
    } store_stat_t;

    // Bits lo..hi-1 of a byte, 0 <= lo < hi <= 8
    function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [3:0] hi);
        logic [8:0] hi_mask;
        hi_mask   = (9'd1 << hi) - 9'd1;
        span_mask = hi_mask[7:0] & (8'hFF << lo);
    endfunction

endpackage
`default_nettype wire

FILE: src/ppbr_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppbr_store
// Bitmap memory with a one-stage read-modify-write path and the clearing
// sweep that runs after reset.
// ----------------------------------------------------------------------------
module ppbr_store
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  ppbr_pkg::rmw_req_t      req,
    output ppbr_pkg::store_stat_t   stat
);

    logic [7:0] mem [0:ppbr_pkg::BITMAP_BYTES-1];

    logic [ppbr_pkg::BYTE_IDX_W-1:0] init_idx_reg;
    logic                            init_done_reg;

    logic                            st_valid_reg;
    logic [ppbr_pkg::BYTE_IDX_W-1:0] st_idx_reg;
    logic [7:0]                      st_mask_reg;
    logic [ppbr_pkg::FUNC_W-1:0]     st_op_reg;
    logic [7:0]                      rd_data_reg;

    logic                            wr_en;
    logic [ppbr_pkg::BYTE_IDX_W-1:0] wr_idx;
    logic [7:0]                      wr_data;

    // Clearing sweep, one byte a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_idx_reg  <= '0;
            init_done_reg <= 1'b0;
        end
        else if (!init_done_reg)
        begin
            if (init_idx_reg == ppbr_pkg::BYTE_IDX_W'(ppbr_pkg::BITMAP_BYTES - 1))
                init_done_reg <= 1'b1;
            else
                init_idx_reg <= init_idx_reg + ppbr_pkg::BYTE_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else
            st_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        st_idx_reg  <= req.idx;
        st_mask_reg <= req.mask;
        st_op_reg   <= req.op;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = st_idx_reg;
        wr_data = rd_data_reg;
        if (!init_done_reg)
        begin
            wr_en   = 1'b1;
            wr_idx  = init_idx_reg;
            wr_data = 8'h00;
        end
        else if (st_valid_reg)
        begin
            case (st_op_reg)
                ppbr_pkg::OP_SET:
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg | st_mask_reg;
                end
                ppbr_pkg::OP_CLEAR:
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg & ~st_mask_reg;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
            rd_data_reg <= mem[req.idx];
    end

    assign stat.init_done = init_done_reg;
    assign stat.pending   = st_valid_reg;
    assign stat.hit       = st_valid_reg && (st_op_reg == ppbr_pkg::OP_TEST)
                            && ((rd_data_reg & st_mask_reg) != 8'h00);

endmodule
`default_nettype wire

FILE: src/page_protection_bitmap_range_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_protection_bitmap_range_unit
// Page protection bitmap with range set, clear and test requests.
// ----------------------------------------------------------------------------
// One protection bit per 4 KiB page lives in a byte-wide synchronous memory
// of BITMAP_BYTES entries. After reset the block sweeps the memory to zero,
// one byte a cycle, and holds in_stall high until the sweep ends. A request
// is taken in S_IDLE, its page range is formed and clipped in S_CALC and
// S_SETUP, S_WALK does one memory read per bitmap byte that the clipped
// range touches through the single read-modify-write stage, S_DRAIN drains
// that stage and S_DONE loads the result register once any previous result
// has left out_valid. An empty range, or the unused operation code, goes
// from S_SETUP straight to S_DONE. A request is taken while the previous
// result still waits on out_stall.
// ----------------------------------------------------------------------------
module page_protection_bitmap_range_unit
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [ppbr_pkg::FUNC_W-1:0]      func,
    input  wire  [ppbr_pkg::ADDR_W-1:0]      phys_addr,
    input  wire  [ppbr_pkg::ADDR_W-1:0]      range_len,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic                             any_protected
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [ppbr_pkg::FUNC_W-1:0]   func_reg;
    logic [ppbr_pkg::ADDR_W-1:0]   addr_reg;
    logic [ppbr_pkg::ADDR_W-1:0]   len_reg;
    logic [ppbr_pkg::END_W-1:0]    end_reg;
    logic [ppbr_pkg::PAGE_W-1:0]   cur_page_reg;
    logic [ppbr_pkg::PAGE_W-1:0]   cur_page_next;
    logic [ppbr_pkg::LAST_W-1:0]   last_reg;
    logic [ppbr_pkg::LAST_W-1:0]   last_next;
    logic                          hit_reg;
    logic                          out_valid_reg;
    logic                          any_reg;

    logic [ppbr_pkg::END_PAGE_W-1:0] first_full;
    logic [ppbr_pkg::END_PAGE_W-1:0] last_full;
    logic [ppbr_pkg::LAST_W-1:0]     last_clip;
    logic                            range_ok;

    logic [ppbr_pkg::PAGE_W-1:0]     base;
    logic [ppbr_pkg::LAST_W-1:0]     rem;
    logic                            last_byte;
    logic [3:0]                      hi;

    logic in_xfer;
    logic out_load;

    ppbr_pkg::rmw_req_t    rmw_req;
    ppbr_pkg::store_stat_t stat;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Page range, clipped to the bitmap
    assign first_full = ppbr_pkg::END_PAGE_W'(addr_reg[ppbr_pkg::ADDR_W-1:ppbr_pkg::PAGE_SHIFT]);
    assign last_full  = end_reg[ppbr_pkg::END_W-1:ppbr_pkg::PAGE_SHIFT];
    assign last_clip  = (last_full > ppbr_pkg::END_PAGE_W'(ppbr_pkg::PAGE_LIMIT))
                        ? ppbr_pkg::PAGE_LIMIT : last_full[ppbr_pkg::LAST_W-1:0];
    assign range_ok   = (func_reg == ppbr_pkg::OP_SET || func_reg == ppbr_pkg::OP_CLEAR
                         || func_reg == ppbr_pkg::OP_TEST)
                        && (first_full < ppbr_pkg::END_PAGE_W'(last_clip));

    // Current byte of the walk
    assign base      = {cur_page_reg[ppbr_pkg::PAGE_W-1:3], 3'b000};
    assign rem       = last_reg - ppbr_pkg::LAST_W'(base);
    assign last_byte = (rem <= ppbr_pkg::LAST_W'(8));
    assign hi        = last_byte ? rem[3:0] : 4'd8;

    always_comb
    begin
        rmw_req.valid = (state_reg == S_WALK);
        rmw_req.idx   = cur_page_reg[ppbr_pkg::PAGE_W-1:3];
        rmw_req.mask  = ppbr_pkg::span_mask(cur_page_reg[2:0], hi);
        rmw_req.op    = func_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_page_next = cur_page_reg;
        last_next     = last_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (stat.init_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cur_page_next = first_full[ppbr_pkg::PAGE_W-1:0];
                last_next     = last_clip;
                state_next    = range_ok ? S_WALK : S_DONE;
            end
            S_WALK:
            begin
                // Advance to the next byte, or leave on the last one
                cur_page_next = base + ppbr_pkg::PAGE_W'(8);
                if (last_byte)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CALC)
                hit_reg <= 1'b0;
            else if (stat.hit)
                hit_reg <= 1'b1;
            out_valid_reg <= (out_valid_reg && out_stall) || out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= func;
            addr_reg <= phys_addr;
            len_reg  <= range_len;
        end
        if (state_reg == S_CALC)
            end_reg <= ppbr_pkg::END_W'(addr_reg) + ppbr_pkg::END_W'(len_reg)
                       + ppbr_pkg::END_W'(ppbr_pkg::PAGE_SIZE - 1);
        cur_page_reg <= cur_page_next;
        last_reg     <= last_next;
        if (out_load)
            any_reg <= (func_reg == ppbr_pkg::OP_TEST) && hit_reg;
    end

    assign out_valid     = out_valid_reg;
    assign any_protected = any_reg;

    ppbr_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rmw_req),
        .stat  (stat)
    );

    // No transfer in before the clearing sweep is over
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> stat.init_done)
        else $error("input transfer during clearing sweep");

    // The last write-back lands before the result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !stat.pending)
        else $error("result loaded with a write-back still pending");

    // A hit only comes from a test request
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.hit |-> (func_reg == ppbr_pkg::OP_TEST))
        else $error("hit on a set or clear request");

    // The walk never reaches the clipped end page
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (ppbr_pkg::LAST_W'(cur_page_reg) < last_reg))
        else $error("walk past the end of the range");

endmodule
`default_nettype wire
